/* hdl/gradient_noise_3d_core_macros.svh */
// Assertion macros shared by the gradient noise RTL.
`ifndef GRADIENT_NOISE_3D_CORE_MACROS_SVH
`define GRADIENT_NOISE_3D_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge out of reset.
`define GN3_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A trigger that forces a condition at the next clock edge.
`define GN3_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GN3_ASSERT(lbl, cond, msg)
`define GN3_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* hdl/gn3_pkg.sv */
// Constants, widths and the permutation ROM of the gradient noise core.
package gn3_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  // Item kinds carried on the mode field.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Datapath widths: corner dots and blends, differences, blend products.
  localparam int DOT_W = 35;
  localparam int DIF_W = DOT_W + 1;
  localparam int MUL_W = DIF_W + 17;

  localparam logic [7:0] PERM [256] = '{
    8'd225, 8'd155, 8'd210, 8'd108, 8'd175, 8'd199, 8'd221, 8'd144,
    8'd203, 8'd116, 8'd70,  8'd213, 8'd69,  8'd158, 8'd33,  8'd252,
    8'd5,   8'd82,  8'd173, 8'd133, 8'd222, 8'd139, 8'd174, 8'd27,
    8'd9,   8'd71,  8'd90,  8'd246, 8'd75,  8'd130, 8'd91,  8'd191,
    8'd169, 8'd138, 8'd2,   8'd151, 8'd194, 8'd235, 8'd81,  8'd7,
    8'd25,  8'd113, 8'd228, 8'd159, 8'd205, 8'd253, 8'd134, 8'd142,
    8'd248, 8'd65,  8'd224, 8'd217, 8'd22,  8'd121, 8'd229, 8'd63,
    8'd89,  8'd103, 8'd96,  8'd104, 8'd156, 8'd17,  8'd201, 8'd129,
    8'd36,  8'd8,   8'd165, 8'd110, 8'd237, 8'd117, 8'd231, 8'd56,
    8'd132, 8'd211, 8'd152, 8'd20,  8'd181, 8'd111, 8'd239, 8'd218,
    8'd170, 8'd163, 8'd51,  8'd172, 8'd157, 8'd47,  8'd80,  8'd212,
    8'd176, 8'd250, 8'd87,  8'd49,  8'd99,  8'd242, 8'd136, 8'd189,
    8'd162, 8'd115, 8'd44,  8'd43,  8'd124, 8'd94,  8'd150, 8'd16,
    8'd141, 8'd247, 8'd32,  8'd10,  8'd198, 8'd223, 8'd255, 8'd72,
    8'd53,  8'd131, 8'd84,  8'd57,  8'd220, 8'd197, 8'd58,  8'd50,
    8'd208, 8'd11,  8'd241, 8'd28,  8'd3,   8'd192, 8'd62,  8'd202,
    8'd18,  8'd215, 8'd153, 8'd24,  8'd76,  8'd41,  8'd15,  8'd179,
    8'd39,  8'd46,  8'd55,  8'd6,   8'd128, 8'd167, 8'd23,  8'd188,
    8'd106, 8'd34,  8'd187, 8'd140, 8'd164, 8'd73,  8'd112, 8'd182,
    8'd244, 8'd195, 8'd227, 8'd13,  8'd35,  8'd77,  8'd196, 8'd185,
    8'd26,  8'd200, 8'd226, 8'd119, 8'd31,  8'd123, 8'd168, 8'd125,
    8'd249, 8'd68,  8'd183, 8'd230, 8'd177, 8'd135, 8'd160, 8'd180,
    8'd12,  8'd1,   8'd243, 8'd148, 8'd102, 8'd166, 8'd38,  8'd238,
    8'd251, 8'd37,  8'd240, 8'd126, 8'd64,  8'd74,  8'd161, 8'd40,
    8'd184, 8'd149, 8'd171, 8'd178, 8'd101, 8'd66,  8'd29,  8'd59,
    8'd146, 8'd61,  8'd254, 8'd107, 8'd42,  8'd86,  8'd154, 8'd4,
    8'd236, 8'd232, 8'd120, 8'd21,  8'd233, 8'd209, 8'd45,  8'd98,
    8'd193, 8'd114, 8'd78,  8'd19,  8'd206, 8'd14,  8'd118, 8'd127,
    8'd48,  8'd79,  8'd147, 8'd85,  8'd30,  8'd207, 8'd219, 8'd54,
    8'd88,  8'd234, 8'd190, 8'd122, 8'd95,  8'd67,  8'd143, 8'd109,
    8'd137, 8'd214, 8'd145, 8'd93,  8'd92,  8'd100, 8'd245, 8'd0,
    8'd216, 8'd186, 8'd60,  8'd83,  8'd105, 8'd97,  8'd204, 8'd52
  };

endpackage

/* hdl/gradient_noise_3d_core.sv */
// Gradient noise core: table load, corner hashing, dot products and trilinear blend.
// Loads are accepted one per cycle unless the output stalls or stage 3 walks corner pairs;
// an evaluation holds the table stage for its four corner pairs, as the gradient memory
// serves two corner reads per cycle (eight corners per point). Loads are written from stage 3.
// Reset clears all valid flags and the corner sequencer; the table is undefined until loaded.
// Output stalls freeze the whole pipeline.
`include "gradient_noise_3d_core_macros.svh"

module gradient_noise_3d_core #(
  parameter int TABLE_SIZE = gn3_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [7:0]         in_grad_index,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_noise_value
);

  localparam int AW    = $clog2(TABLE_SIZE);
  localparam int DOT_W = gn3_pkg::DOT_W;
  localparam int DIF_W = gn3_pkg::DIF_W;
  localparam int MUL_W = gn3_pkg::MUL_W;
  localparam int RND_W = DOT_W - 15;

  // Hashed or loaded byte taken modulo the table size.
  function automatic logic [AW-1:0] to_addr(input logic [7:0] b);
    logic [AW+7:0] ext;
    ext = {{AW{1'b0}}, b};
    return ext[AW-1:0];
  endfunction

  // Enables: stages move while the output can take data; stages 0-3 also need stage 3 free.
  logic en, adv, s3_done, s3_free;

  // Stage 0: accepted transaction.
  logic               s0_v_r, s0_mode_r;
  logic [7:0]         s0_idx_r;
  logic [47:0]        s0_g_r;
  logic [31:0]        s0_c_r [3];

  // Stage 1: cell, fraction, weight partials, first hash level.
  logic               s1_v_r, s1_mode_r;
  logic [7:0]         s1_idx_r;
  logic [47:0]        s1_g_r;
  logic [7:0]         s1_cell_r [3];
  logic [15:0]        s1_t_r [3];
  logic [31:0]        s1_tsq_r [3];
  logic [17:0]        s1_k_r [3];
  logic [7:0]         s1_pz_r [2];
  logic [15:0]        t_w [3];

  // Stage 2: weights and second hash level.
  logic               s2_v_r, s2_mode_r;
  logic [7:0]         s2_idx_r;
  logic [47:0]        s2_g_r;
  logic [7:0]         s2_cx_r;
  logic [15:0]        s2_t_r [3];
  logic [15:0]        s2_w_r [3];
  logic [7:0]         s2_py_r [4];

  // Stage 3: corner hashes, held while the sequencer walks the corner pairs.
  logic               s3_v_r, s3_eval_r;
  logic [7:0]         s3_idx_r;
  logic [47:0]        s3_g_r;
  logic [15:0]        s3_t_r [3];
  logic [15:0]        s3_w_r [3];
  logic [7:0]         s3_hlo_r [4];
  logic [7:0]         s3_hhi_r [4];
  logic [1:0]         seq_k_r;
  logic               iss_v, mem_we;

  // Gradient table and its two registered read ports.
  logic [47:0]        grad_mem [TABLE_SIZE];
  logic [47:0]        rd_a_r, rd_b_r;

  // Stage 4 to 8: corner pair datapath.
  logic               s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic [1:0]         s4_k_r, s5_k_r, s6_k_r, s7_k_r, s8_k_r;
  logic signed [16:0] s4_o_r [4];
  logic [15:0]        s4_w_r [3], s5_w_r [3], s6_w_r [3], s7_w_r [3], s8_w_r [3];
  logic signed [32:0] s5_p_r [6];
  logic signed [DOT_W-1:0] s6_da_r, s6_db_r, s7_da_r, s8_da_r;
  logic signed [DIF_W-1:0] s7_dif_r;
  logic signed [MUL_W-1:0] s8_prod_r;

  // Collector of the four x blends and the y and z blend stages.
  logic               c_v_r;
  logic signed [DOT_W-1:0] x_r [4];
  logic [15:0]        c_wy_r, c_wz_r;
  logic               y1_v_r, y2_v_r, y3_v_r, z1_v_r, z2_v_r, z3_v_r;
  logic signed [DIF_W-1:0] y1_d_r [2];
  logic signed [DOT_W-1:0] y1_x_r [2], y2_x_r [2];
  logic [15:0]        y1_wz_r, y2_wz_r, y3_wz_r, z1_wz_r;
  logic signed [16:0] y1_wy_r;
  logic signed [MUL_W-1:0] y2_p_r [2];
  logic signed [DOT_W-1:0] y3_z_r [2], z1_z0_r, z2_z0_r, z3_s_r;
  logic signed [DIF_W-1:0] z1_d_r;
  logic signed [MUL_W-1:0] z2_p_r;

  // Output register.
  logic               out_valid_r;
  logic signed [15:0] out_noise_r;
  logic signed [DOT_W:0]   rnd_sum;
  logic signed [RND_W-1:0] rnd_w;
  logic signed [15:0]      sat_w;

  assign en       = !out_valid_r || out_ready;
  assign s3_done  = s3_v_r && (!s3_eval_r || (seq_k_r == 2'd3));
  assign s3_free  = !s3_v_r || s3_done;
  assign adv      = en && s3_free;
  assign in_ready = adv;
  assign iss_v    = s3_v_r && s3_eval_r;
  assign mem_we   = en && s3_v_r && !s3_eval_r;

  // Control state of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end else if (en && s3_done) begin
      s3_v_r <= 1'b0;
    end
  end

  // Fraction brought to sixteen bits, per axis.
  for (genvar a = 0; a < 3; a++) begin : g_frac
    if (FRAC_BITS >= 16) begin : g_trunc
      assign t_w[a] = s0_c_r[a][FRAC_BITS-1 -: 16];
    end else begin : g_shift
      assign t_w[a] = {s0_c_r[a][FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    end
  end

  // Front stage payload: split, smoothstep partials and the hash chain.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_mode_r <= in_mode;
      s0_idx_r  <= in_grad_index;
      s0_g_r    <= {in_grad_z, in_grad_y, in_grad_x};
      s0_c_r[0] <= in_coord_x;
      s0_c_r[1] <= in_coord_y;
      s0_c_r[2] <= in_coord_z;

      s1_mode_r <= s0_mode_r;
      s1_idx_r  <= s0_idx_r;
      s1_g_r    <= s0_g_r;
      for (int a = 0; a < 3; a++) begin
        s1_cell_r[a] <= s0_c_r[a][FRAC_BITS +: 8];
        s1_t_r[a]    <= t_w[a];
        s1_tsq_r[a]  <= 32'(t_w[a]) * 32'(t_w[a]);
        s1_k_r[a]    <= 18'd196608 - {1'b0, t_w[a], 1'b0};
      end
      s1_pz_r[0] <= gn3_pkg::PERM[s0_c_r[2][FRAC_BITS +: 8]];
      s1_pz_r[1] <= gn3_pkg::PERM[8'(s0_c_r[2][FRAC_BITS +: 8] + 8'd1)];

      s2_mode_r <= s1_mode_r;
      s2_idx_r  <= s1_idx_r;
      s2_g_r    <= s1_g_r;
      s2_cx_r   <= s1_cell_r[0];
      for (int a = 0; a < 3; a++) begin
        s2_t_r[a] <= s1_t_r[a];
        s2_w_r[a] <= 16'((50'(s1_tsq_r[a]) * 50'(s1_k_r[a])) >> 32);
      end
      s2_py_r[0] <= gn3_pkg::PERM[8'(s1_cell_r[1] + s1_pz_r[0])];
      s2_py_r[1] <= gn3_pkg::PERM[8'(s1_cell_r[1] + 8'd1 + s1_pz_r[0])];
      s2_py_r[2] <= gn3_pkg::PERM[8'(s1_cell_r[1] + s1_pz_r[1])];
      s2_py_r[3] <= gn3_pkg::PERM[8'(s1_cell_r[1] + 8'd1 + s1_pz_r[1])];

      s3_eval_r <= (s2_mode_r == gn3_pkg::MODE_EVAL);
      s3_idx_r  <= s2_idx_r;
      s3_g_r    <= s2_g_r;
      for (int a = 0; a < 3; a++) begin
        s3_t_r[a] <= s2_t_r[a];
        s3_w_r[a] <= s2_w_r[a];
      end
      for (int k = 0; k < 4; k++) begin
        s3_hlo_r[k] <= gn3_pkg::PERM[8'(s2_cx_r + s2_py_r[k])];
        s3_hhi_r[k] <= gn3_pkg::PERM[8'(s2_cx_r + 8'd1 + s2_py_r[k])];
      end
    end
  end

  // Corner pair sequencer: pair k covers the y offset in bit 0 and the z offset in bit 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_k_r <= 2'd0;
    end else if (en && iss_v) begin
      seq_k_r <= seq_k_r + 2'd1;
    end
  end

  // Gradient table: loads write in order with the evaluation reads.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grad_mem[to_addr(s3_idx_r)] <= s3_g_r;
    end
    if (en) begin
      rd_a_r <= grad_mem[to_addr(s3_hlo_r[seq_k_r])];
      rd_b_r <= grad_mem[to_addr(s3_hhi_r[seq_k_r])];
    end
  end

  // Valid flags of the corner datapath and the blend stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
      c_v_r  <= 1'b0;
      y1_v_r <= 1'b0;
      y2_v_r <= 1'b0;
      y3_v_r <= 1'b0;
      z1_v_r <= 1'b0;
      z2_v_r <= 1'b0;
      z3_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= iss_v;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
      c_v_r  <= s8_v_r && (s8_k_r == 2'd3);
      y1_v_r <= c_v_r;
      y2_v_r <= y1_v_r;
      y3_v_r <= y2_v_r;
      z1_v_r <= y3_v_r;
      z2_v_r <= z1_v_r;
      z3_v_r <= z2_v_r;
      out_valid_r <= z3_v_r;
    end
  end

  // Rounding to Q1.15 and saturation.
  always_comb begin
    rnd_sum = (DOT_W+1)'(z3_s_r) + (DOT_W+1)'(32768);
    rnd_w   = RND_W'(rnd_sum >>> 16);
    if (rnd_w > RND_W'(32767)) begin
      sat_w = 16'sd32767;
    end else if (rnd_w < -RND_W'(32768)) begin
      sat_w = -16'sd32768;
    end else begin
      sat_w = 16'(rnd_w);
    end
  end

  // Corner dot products, x blend, collection and the y and z blends.
  always_ff @(posedge clk) begin
    if (en) begin
      s4_k_r    <= seq_k_r;
      s4_o_r[0] <= {1'b0, s3_t_r[0]};
      s4_o_r[1] <= {1'b1, s3_t_r[0]};
      s4_o_r[2] <= {seq_k_r[0], s3_t_r[1]};
      s4_o_r[3] <= {seq_k_r[1], s3_t_r[2]};
      s4_w_r    <= s3_w_r;

      s5_k_r    <= s4_k_r;
      s5_w_r    <= s4_w_r;
      s5_p_r[0] <= 33'($signed(rd_a_r[15:0]))  * 33'(s4_o_r[0]);
      s5_p_r[1] <= 33'($signed(rd_a_r[31:16])) * 33'(s4_o_r[2]);
      s5_p_r[2] <= 33'($signed(rd_a_r[47:32])) * 33'(s4_o_r[3]);
      s5_p_r[3] <= 33'($signed(rd_b_r[15:0]))  * 33'(s4_o_r[1]);
      s5_p_r[4] <= 33'($signed(rd_b_r[31:16])) * 33'(s4_o_r[2]);
      s5_p_r[5] <= 33'($signed(rd_b_r[47:32])) * 33'(s4_o_r[3]);

      s6_k_r  <= s5_k_r;
      s6_w_r  <= s5_w_r;
      s6_da_r <= DOT_W'(s5_p_r[0]) + DOT_W'(s5_p_r[1]) + DOT_W'(s5_p_r[2]);
      s6_db_r <= DOT_W'(s5_p_r[3]) + DOT_W'(s5_p_r[4]) + DOT_W'(s5_p_r[5]);

      s7_k_r   <= s6_k_r;
      s7_w_r   <= s6_w_r;
      s7_da_r  <= s6_da_r;
      s7_dif_r <= DIF_W'(s6_db_r) - DIF_W'(s6_da_r);

      s8_k_r    <= s7_k_r;
      s8_w_r    <= s7_w_r;
      s8_da_r   <= s7_da_r;
      s8_prod_r <= MUL_W'(s7_dif_r) * MUL_W'($signed({1'b0, s7_w_r[0]}));

      if (s8_v_r) begin
        x_r[s8_k_r] <= DOT_W'(MUL_W'(s8_da_r) + (s8_prod_r >>> 16));
        c_wy_r      <= s8_w_r[1];
        c_wz_r      <= s8_w_r[2];
      end

      y1_d_r[0] <= DIF_W'(x_r[1]) - DIF_W'(x_r[0]);
      y1_d_r[1] <= DIF_W'(x_r[3]) - DIF_W'(x_r[2]);
      y1_x_r[0] <= x_r[0];
      y1_x_r[1] <= x_r[2];
      y1_wy_r   <= $signed({1'b0, c_wy_r});
      y1_wz_r   <= c_wz_r;

      y2_p_r[0] <= MUL_W'(y1_d_r[0]) * MUL_W'(y1_wy_r);
      y2_p_r[1] <= MUL_W'(y1_d_r[1]) * MUL_W'(y1_wy_r);
      y2_x_r    <= y1_x_r;
      y2_wz_r   <= y1_wz_r;

      y3_z_r[0] <= DOT_W'(MUL_W'(y2_x_r[0]) + (y2_p_r[0] >>> 16));
      y3_z_r[1] <= DOT_W'(MUL_W'(y2_x_r[1]) + (y2_p_r[1] >>> 16));
      y3_wz_r   <= y2_wz_r;

      z1_d_r  <= DIF_W'(y3_z_r[1]) - DIF_W'(y3_z_r[0]);
      z1_z0_r <= y3_z_r[0];
      z1_wz_r <= y3_wz_r;

      z2_p_r  <= MUL_W'(z1_d_r) * MUL_W'($signed({1'b0, z1_wz_r}));
      z2_z0_r <= z1_z0_r;

      z3_s_r  <= DOT_W'(MUL_W'(z2_z0_r) + (z2_p_r >>> 16));

      out_noise_r <= sat_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

  // Checks on the sequencer, the table port and the collector.
  `GN3_ASSERT(a_seq_idle, (seq_k_r != 2'd0) |-> (s3_v_r && s3_eval_r), "sequencer runs without an evaluation")
  `GN3_ASSERT(a_load_between, mem_we |-> (seq_k_r == 2'd0), "table load in the middle of a corner walk")
  `GN3_ASSERT_NEXT(a_collect, (en && s8_v_r && s8_k_r == 2'd3), c_v_r, "last corner pair not collected")
  `GN3_ASSERT(a_accept_room, in_ready |-> (!out_valid_r || out_ready), "transaction accepted into a stalled pipeline")

endmodule
